// ----- sv/bpli_pkg.sv -----
// Shared constants, codes and types for the binned PDF linear interpolation block.
package bpli_pkg;

    localparam int NUM_BINS   = 64;
    localparam int EDGE_DEPTH = NUM_BINS + 1;
    localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
    localparam int BIN_AW     = $clog2(NUM_BINS);
    localparam int FIRST_W    = $clog2(NUM_BINS + 2);
    localparam int MID0       = (NUM_BINS + 1) / 2;

    localparam int IDX_W      = 7;
    localparam int VAL_W      = 16;
    localparam int OPC_W      = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam int PROD_W     = 2 * (VAL_W + 1);
    localparam int REM_W      = 2 * VAL_W + 1;
    localparam int DSH_W      = 2 * VAL_W - 1;
    localparam int QCNT_W     = $clog2(VAL_W + 1);

    typedef enum logic [OPC_W-1:0] {
        OPC_WR_EDGE = 2'd0,
        OPC_WR_BIN  = 2'd1,
        OPC_EVAL    = 2'd2
    } op_code_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_WRITE,
        DP_RD_E1,
        DP_CHK_E1,
        DP_CHK_EN,
        DP_PROBE,
        DP_SET_B,
        DP_RD_FLAT,
        DP_GET_FLAT,
        DP_NB0,
        DP_NB1,
        DP_NB2,
        DP_NB3,
        DP_NB4,
        DP_CENTER,
        DP_SELECT,
        DP_MUL1,
        DP_MUL2,
        DP_NUM,
        DP_ABS,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_FINISH,
        DP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,
        ST_E1_RD,
        ST_E1_CHK,
        ST_EN_CHK,
        ST_PROBE,
        ST_SET_B,
        ST_B_CHK,
        ST_FLAT_RD,
        ST_FLAT_GET,
        ST_NB0,
        ST_NB1,
        ST_NB2,
        ST_NB3,
        ST_NB4,
        ST_CENTER,
        ST_SELECT,
        ST_MUL1,
        ST_MUL2,
        ST_NUM,
        ST_ABS,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic lt_e1;
        logic gt_en;
        logic search_end;
        logic b_outer;
        logic flat;
        logic skip_div;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/bpli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bpli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/bpli_dp.sv -----
// Datapath: edge and content tables, search registers, multiplier, divider, output register.
module bpli_dp import bpli_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_op_t               dp_op,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OPC_W-1:0]     s_tuser,
    output dp_status_t           status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [VAL_W-1:0]         x_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [OPC_W-1:0]         opc_reg;
    logic [FIRST_W-1:0]       first_reg;
    logic [FIRST_W-1:0]       len_reg;
    logic [FIRST_W-1:0]       mid_reg;
    logic [BIN_AW-1:0]        b_reg;
    logic [VAL_W-1:0]         ea_reg, eb_reg, ec_reg, ed_reg;
    logic [VAL_W-1:0]         ya_reg, yb_reg, yc_reg;
    logic [VAL_W-1:0]         ca_reg, cb_reg, cc_reg;
    logic [VAL_W-1:0]         y1_reg, y2_reg;
    logic signed [VAL_W:0]    d1_reg, d2_reg, den_reg;
    logic                     flat_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, num_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [VAL_W-1:0]         dabs_reg;
    logic [DSH_W-1:0]         dsh_reg;
    logic                     neg_reg, ovf_reg;
    logic [VAL_W-1:0]         q_reg;
    logic [QCNT_W-1:0]        cnt_reg;
    logic [VAL_W-1:0]         res_reg;
    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;

    logic                     edge_we, bin_we;
    logic [EDGE_AW-1:0]       edge_raddr;
    logic [BIN_AW-1:0]        bin_raddr;
    logic [VAL_W-1:0]         edge_q, bin_q;

    logic [FIRST_W-1:0]       half, nfirst, nlen, nmid, s_idx;
    logic [EDGE_AW-1:0]       probe_addr;
    logic                     eq_hit;
    logic [BIN_AW-1:0]        b_next;

    logic                     lower, upper, top_bin;
    logic [VAL_W-1:0]         x1, x2, y1, y2;

    logic [VAL_W-1:0]         mul_y;
    logic signed [VAL_W:0]    mul_d;
    logic signed [PROD_W-1:0] mul_p;
    logic [PROD_W-1:0]        num_mag;
    logic [VAL_W:0]           den_mag;

    function automatic logic [VAL_W-1:0] mid_of(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W:1];
    endfunction

    assign edge_we = (dp_op == DP_WRITE) && (opc_reg == OPC_WR_EDGE)
                     && (int'(idx_reg) <= NUM_BINS);
    assign bin_we  = (dp_op == DP_WRITE) && (opc_reg == OPC_WR_BIN)
                     && (int'(idx_reg) < NUM_BINS);

    bpli_ram #(.WIDTH(VAL_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (EDGE_AW'(idx_reg)),
        .wdata (x_reg),
        .raddr (edge_raddr),
        .rdata (edge_q)
    );

    bpli_ram #(.WIDTH(VAL_W), .DEPTH(NUM_BINS)) u_bin_ram (
        .aclk  (aclk),
        .we    (bin_we),
        .waddr (BIN_AW'(idx_reg)),
        .wdata (x_reg),
        .raddr (bin_raddr),
        .rdata (bin_q)
    );

    always_comb begin
        half = len_reg >> 1;
        if (edge_q < x_reg) begin
            nfirst = mid_reg + 1'b1;
            nlen   = len_reg - half - 1'b1;
        end else begin
            nfirst = first_reg;
            nlen   = half;
        end
        nmid = nfirst + (nlen >> 1);
        if (int'(nmid) > NUM_BINS) begin
            probe_addr = EDGE_AW'(NUM_BINS);
        end else begin
            probe_addr = EDGE_AW'(nmid);
        end
    end

    always_comb begin
        eq_hit = (int'(first_reg) <= NUM_BINS) && (edge_q == x_reg);
        s_idx  = eq_hit ? first_reg : first_reg - 1'b1;
        if (!eq_hit && (first_reg == '0)) begin
            b_next = '0;
        end else if (int'(s_idx) > NUM_BINS - 1) begin
            b_next = BIN_AW'(NUM_BINS - 1);
        end else begin
            b_next = BIN_AW'(s_idx);
        end
    end

    always_comb begin
        unique case (dp_op)
            DP_RD_E1:  edge_raddr = EDGE_AW'(1);
            DP_CHK_E1: edge_raddr = EDGE_AW'(NUM_BINS - 1);
            DP_CHK_EN: edge_raddr = EDGE_AW'(MID0);
            DP_PROBE:  edge_raddr = probe_addr;
            DP_NB0:    edge_raddr = EDGE_AW'(b_reg) - 1'b1;
            DP_NB1:    edge_raddr = EDGE_AW'(b_reg);
            DP_NB2:    edge_raddr = EDGE_AW'(b_reg) + 1'b1;
            DP_NB3:    edge_raddr = EDGE_AW'(b_reg) + EDGE_AW'(2);
            default:   edge_raddr = '0;
        endcase
        unique case (dp_op)
            DP_RD_FLAT: bin_raddr = b_reg;
            DP_NB0:     bin_raddr = b_reg - 1'b1;
            DP_NB1:     bin_raddr = b_reg;
            DP_NB2:     bin_raddr = b_reg + 1'b1;
            default:    bin_raddr = '0;
        endcase
    end

    always_comb begin
        lower   = (x_reg < cb_reg) && (x_reg >= eb_reg);
        upper   = (x_reg >= cb_reg) && (x_reg <= ec_reg);
        top_bin = (b_reg == BIN_AW'(NUM_BINS - 2));
        x1 = '0;
        x2 = '0;
        y1 = '0;
        y2 = '0;
        priority if (lower) begin
            x1 = ca_reg;
            y1 = ya_reg;
            x2 = cb_reg;
            y2 = yb_reg;
        end else if (upper) begin
            x1 = cb_reg;
            y1 = yb_reg;
            x2 = top_bin ? cb_reg : cc_reg;
            y2 = top_bin ? yb_reg : yc_reg;
        end
    end

    assign mul_y = (dp_op == DP_MUL2) ? y1_reg : y2_reg;
    assign mul_d = (dp_op == DP_MUL2) ? d2_reg : d1_reg;
    assign mul_p = $signed({1'b0, mul_y}) * mul_d;

    assign num_mag = num_reg[PROD_W-1] ? PROD_W'(-num_reg) : PROD_W'(num_reg);
    assign den_mag = den_reg[VAL_W] ? (VAL_W+1)'(-den_reg) : (VAL_W+1)'(den_reg);

    always_ff @(posedge aclk) begin
        unique case (dp_op)
            DP_LOAD: begin
                idx_reg <= s_tdata[IDX_W-1:0];
                x_reg   <= s_tdata[IDX_W+VAL_W-1:IDX_W];
                opc_reg <= s_tuser;
            end
            DP_CHK_E1: begin
                b_reg <= '0;
            end
            DP_CHK_EN: begin
                b_reg     <= BIN_AW'(NUM_BINS - 1);
                first_reg <= '0;
                len_reg   <= FIRST_W'(NUM_BINS + 1);
                mid_reg   <= FIRST_W'(MID0);
            end
            DP_PROBE: begin
                first_reg <= nfirst;
                len_reg   <= nlen;
                mid_reg   <= nmid;
            end
            DP_SET_B: begin
                b_reg <= b_next;
            end
            DP_GET_FLAT: begin
                res_reg <= bin_q;
            end
            DP_NB1: begin
                ea_reg <= edge_q;
                ya_reg <= bin_q;
            end
            DP_NB2: begin
                eb_reg <= edge_q;
                yb_reg <= bin_q;
            end
            DP_NB3: begin
                ec_reg <= edge_q;
                yc_reg <= bin_q;
            end
            DP_NB4: begin
                ed_reg <= edge_q;
            end
            DP_CENTER: begin
                ca_reg <= mid_of(ea_reg, eb_reg);
                cb_reg <= mid_of(eb_reg, ec_reg);
                cc_reg <= mid_of(ec_reg, ed_reg);
            end
            DP_SELECT: begin
                y1_reg   <= y1;
                y2_reg   <= y2;
                d1_reg   <= $signed({1'b0, x_reg}) - $signed({1'b0, x1});
                d2_reg   <= $signed({1'b0, x_reg}) - $signed({1'b0, x2});
                den_reg  <= $signed({1'b0, x2}) - $signed({1'b0, x1});
                flat_reg <= (x1 == x2);
            end
            DP_MUL1: begin
                p1_reg <= mul_p;
            end
            DP_MUL2: begin
                p2_reg <= mul_p;
            end
            DP_NUM: begin
                num_reg <= p1_reg - p2_reg;
            end
            DP_ABS: begin
                rem_reg  <= num_mag[REM_W-1:0];
                dabs_reg <= den_mag[VAL_W-1:0];
                neg_reg  <= num_reg[PROD_W-1] ^ den_reg[VAL_W];
            end
            DP_DIV_INIT: begin
                ovf_reg <= rem_reg >= REM_W'({dabs_reg, {VAL_W{1'b0}}});
                dsh_reg <= {dabs_reg, {(VAL_W-1){1'b0}}};
                cnt_reg <= QCNT_W'(VAL_W);
                q_reg   <= '0;
            end
            DP_DIV_STEP: begin
                if (rem_reg >= REM_W'(dsh_reg)) begin
                    rem_reg <= rem_reg - REM_W'(dsh_reg);
                    q_reg   <= {q_reg[VAL_W-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[VAL_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            DP_FINISH: begin
                if (flat_reg) begin
                    res_reg <= y1_reg;
                end else if (neg_reg) begin
                    res_reg <= '0;
                end else if (ovf_reg) begin
                    res_reg <= '1;
                end else begin
                    res_reg <= q_reg;
                end
            end
            DP_OUT: begin
                m_tdata_reg <= M_TDATA_W'(res_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (dp_op == DP_OUT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        status.lt_e1      = x_reg < edge_q;
        status.gt_en      = x_reg > edge_q;
        status.search_end = (nlen == '0);
        status.b_outer    = (b_reg == '0) || (b_reg == BIN_AW'(NUM_BINS - 1));
        status.flat       = flat_reg;
        status.skip_div   = neg_reg || ovf_reg;
        status.div_last   = (cnt_reg == QCNT_W'(1));
        status.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

// ----- sv/bpli_ctrl.sv -----
// Controller state machine that sequences the datapath for writes and evaluations.
module bpli_ctrl import bpli_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [OPC_W-1:0] s_tuser,
    input  dp_status_t       status,
    output dp_op_t           dp_op
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (op_code_t'(s_tuser))
                        OPC_WR_EDGE, OPC_WR_BIN: state_next = ST_WRITE;
                        OPC_EVAL:                state_next = ST_E1_RD;
                        default:                 state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:    state_next = ST_IDLE;
            ST_E1_RD:    state_next = ST_E1_CHK;
            ST_E1_CHK:   state_next = status.lt_e1 ? ST_FLAT_RD : ST_EN_CHK;
            ST_EN_CHK:   state_next = status.gt_en ? ST_FLAT_RD : ST_PROBE;
            ST_PROBE:    state_next = status.search_end ? ST_SET_B : ST_PROBE;
            ST_SET_B:    state_next = ST_B_CHK;
            ST_B_CHK:    state_next = status.b_outer ? ST_FLAT_RD : ST_NB0;
            ST_FLAT_RD:  state_next = ST_FLAT_GET;
            ST_FLAT_GET: state_next = ST_OUT;
            ST_NB0:      state_next = ST_NB1;
            ST_NB1:      state_next = ST_NB2;
            ST_NB2:      state_next = ST_NB3;
            ST_NB3:      state_next = ST_NB4;
            ST_NB4:      state_next = ST_CENTER;
            ST_CENTER:   state_next = ST_SELECT;
            ST_SELECT:   state_next = ST_MUL1;
            ST_MUL1:     state_next = status.flat ? ST_FINISH : ST_MUL2;
            ST_MUL2:     state_next = ST_NUM;
            ST_NUM:      state_next = ST_ABS;
            ST_ABS:      state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV: begin
                if (status.skip_div || status.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:   state_next = ST_OUT;
            ST_OUT:      state_next = status.out_free ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        dp_op    = DP_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                dp_op    = s_tvalid ? DP_LOAD : DP_NOP;
            end
            ST_WRITE:    dp_op = DP_WRITE;
            ST_E1_RD:    dp_op = DP_RD_E1;
            ST_E1_CHK:   dp_op = DP_CHK_E1;
            ST_EN_CHK:   dp_op = DP_CHK_EN;
            ST_PROBE:    dp_op = DP_PROBE;
            ST_SET_B:    dp_op = DP_SET_B;
            ST_B_CHK:    dp_op = DP_NOP;
            ST_FLAT_RD:  dp_op = DP_RD_FLAT;
            ST_FLAT_GET: dp_op = DP_GET_FLAT;
            ST_NB0:      dp_op = DP_NB0;
            ST_NB1:      dp_op = DP_NB1;
            ST_NB2:      dp_op = DP_NB2;
            ST_NB3:      dp_op = DP_NB3;
            ST_NB4:      dp_op = DP_NB4;
            ST_CENTER:   dp_op = DP_CENTER;
            ST_SELECT:   dp_op = DP_SELECT;
            ST_MUL1:     dp_op = DP_MUL1;
            ST_MUL2:     dp_op = DP_MUL2;
            ST_NUM:      dp_op = DP_NUM;
            ST_ABS:      dp_op = DP_ABS;
            ST_DIV_INIT: dp_op = DP_DIV_INIT;
            ST_DIV:      dp_op = status.skip_div ? DP_NOP : DP_DIV_STEP;
            ST_FINISH:   dp_op = DP_FINISH;
            ST_OUT:      dp_op = status.out_free ? DP_OUT : DP_NOP;
            default:     dp_op = DP_NOP;
        endcase
    end

endmodule

// ----- sv/binned_pdf_linear_interpolation.sv -----
// Top level of the binned PDF linear interpolation block: controller, datapath and checks.
// A table write passes through the write state before the next transfer can be accepted.
// An evaluation raises m_tvalid after checks against edge 1 and edge 63, a binary search of the
// edges, and in an outer bin a content read or else interpolation (7 probes, 16 divide steps).
// One item is processed at a time; a new transfer is taken once the result is registered.
// Reset clears the controller and the output valid; table contents are undefined until written.
module binned_pdf_linear_interpolation import bpli_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // table_index, data_value, zero pad
    input  logic [OPC_W-1:0]     s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // pdf_value
);

    dp_op_t     dp_op;
    dp_status_t status;

    bpli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .dp_op    (dp_op)
    );

    bpli_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dp_op    (dp_op),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OPC_WR_EDGE || s_tuser == OPC_WR_BIN
                                 || s_tuser == OPC_EVAL) |=> !s_tready)
        else $error("block stayed ready after accepting a transfer");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(dp_op == DP_OUT))
        else $error("result valid rose without an output command");

    a_out_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_op == DP_OUT |-> (!m_tvalid || m_tready))
        else $error("result register overwritten before its transfer");

    a_no_accept_while_working: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_op != DP_NOP && dp_op != DP_LOAD |-> !s_tready)
        else $error("input ready while an item is still in progress");

endmodule
